// ----- src/igde_pkg.sv -----
package igde_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_QUAT_W    = 3'd0,
        REG_QUAT_X    = 3'd1,
        REG_QUAT_Y    = 3'd2,
        REG_QUAT_Z    = 3'd3,
        REG_EMA_ALPHA = 3'd4,
        REG_AVG_COUNT = 3'd5,
        REG_MIN_NORM  = 3'd6
    } t_reg_index;

    localparam logic [16:0] ALPHA_ONE   = 17'h10000;
    localparam logic [12:0] MAX_AVERAGE = 13'd4096;
    localparam logic [15:0] DIR_ONE     = 16'd16384;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [16:0] ema_alpha;
        logic        [12:0] average_count;
        logic        [15:0] min_norm;
    } t_cfg;

    // One queued word: the command flag and the negated sample (gravity).
    typedef struct packed {
        logic               command;
        logic signed [16:0] gx;
        logic signed [16:0] gy;
        logic signed [16:0] gz;
    } t_item;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               batch_done;
    } t_result;

endpackage

// ----- src/igde_front.sv -----
module igde_front import igde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [47:0] i_data,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push;

    // Gravity is the negated reading; 17 bits hold the negation of -32768.
    always_comb begin
        w_item.command = i_command;
        w_item.gx = -$signed({i_data[15], i_data[15:0]});
        w_item.gy = -$signed({i_data[31], i_data[31:16]});
        w_item.gz = -$signed({i_data[47], i_data[47:32]});
    end

    assign o_ready      = (r_count != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/igde_back.sv -----
module igde_back import igde_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CHECK  = 13'b0000000000010,
        S_ROT1   = 13'b0000000000100,
        S_ROT2   = 13'b0000000001000,
        S_UPD    = 13'b0000000010000,
        S_EMA    = 13'b0000000100000,
        S_NORM   = 13'b0000001000000,
        S_SHIFT  = 13'b0000010000000,
        S_SQ     = 13'b0000100000000,
        S_SQRT   = 13'b0001000000000,
        S_DIVSET = 13'b0010000000000,
        S_DIV    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state              r_state;
    logic [4:0]          r_step;
    logic [1:0]          r_axis;
    logic signed [16:0]  r_g [3];
    logic signed [34:0]  r_t [3];
    logic signed [31:0]  r_r [3];
    logic signed [31:0]  r_accum [3];
    logic [12:0]         r_samples;
    logic                r_seen;
    logic                r_fin;
    logic                r_done;
    logic [31:0]         r_mag [3];
    logic                r_neg [3];
    logic signed [63:0]  r_acc;
    logic signed [68:0]  r_prod;
    logic [63:0]         r_v;
    logic [63:0]         r_root;
    logic [63:0]         r_bit;
    logic [31:0]         r_rem;
    logic [15:0]         r_nlo;
    logic [15:0]         r_q;
    logic signed [15:0]  r_dir [3];
    logic                r_out_valid;
    t_result             r_res;

    logic signed [32:0]  w_ma;
    logic signed [35:0]  w_mb;
    logic signed [63:0]  w_p;
    logic [16:0]         w_alpha;
    logic [16:0]         w_beta;
    logic [12:0]         w_cnt;
    logic [31:0]         w_or;
    logic [63:0]         w_trial;
    logic [32:0]         w_rem2;
    logic                w_ge;
    logic [15:0]         w_qn;
    logic [47:0]         w_num;
    logic                w_out_free;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(x);
    endfunction

    // Half away from zero: a negative value takes one less before the shift.
    function automatic logic signed [31:0] rnd28(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + (x[63] ? 64'sd134217727 : 64'sd134217728);
        return 32'(y >>> 28);
    endfunction

    function automatic logic signed [31:0] rnd16_sat(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + (x[63] ? 64'sd32767 : 64'sd32768);
        return sat32(y >>> 16);
    endfunction

    assign w_alpha    = (i_cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.ema_alpha;
    assign w_beta     = ALPHA_ONE - w_alpha;
    assign w_cnt      = (i_cfg.average_count > MAX_AVERAGE) ? MAX_AVERAGE
                                                             : i_cfg.average_count;
    assign w_p        = 64'(r_prod);
    assign w_or       = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_trial    = r_root + r_bit;
    assign w_rem2     = {r_rem, r_nlo[15]};
    assign w_ge       = (w_rem2 >= {1'b0, r_root[31:0]});
    assign w_qn       = {r_q[14:0], w_ge};
    assign w_num      = (48'(r_mag[r_axis]) << 14) + 48'(r_root[31:1]);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

    // Operand select for the shared multiplier, whose product is registered.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_CHECK: begin
                case (r_step)
                    5'd0:    begin w_ma = 33'(r_g[0]); w_mb = 36'(r_g[0]); end
                    5'd1:    begin w_ma = 33'(r_g[1]); w_mb = 36'(r_g[1]); end
                    5'd2:    begin w_ma = 33'(r_g[2]); w_mb = 36'(r_g[2]); end
                    5'd3:    begin
                        w_ma = 33'(i_cfg.min_norm);
                        w_mb = 36'(i_cfg.min_norm);
                    end
                    default: ;
                endcase
            end
            S_ROT1: begin
                case (r_step)
                    5'd0:    begin w_ma = 33'(i_cfg.quat_y); w_mb = 36'(r_g[2]); end
                    5'd1:    begin w_ma = 33'(i_cfg.quat_z); w_mb = 36'(r_g[1]); end
                    5'd2:    begin w_ma = 33'(i_cfg.quat_z); w_mb = 36'(r_g[0]); end
                    5'd3:    begin w_ma = 33'(i_cfg.quat_x); w_mb = 36'(r_g[2]); end
                    5'd4:    begin w_ma = 33'(i_cfg.quat_x); w_mb = 36'(r_g[1]); end
                    5'd5:    begin w_ma = 33'(i_cfg.quat_y); w_mb = 36'(r_g[0]); end
                    default: ;
                endcase
            end
            S_ROT2: begin
                case (r_step)
                    5'd0:    begin w_ma = 33'(i_cfg.quat_w); w_mb = 36'(r_t[0]); end
                    5'd1:    begin w_ma = 33'(i_cfg.quat_y); w_mb = 36'(r_t[2]); end
                    5'd2:    begin w_ma = 33'(i_cfg.quat_z); w_mb = 36'(r_t[1]); end
                    5'd3:    begin w_ma = 33'(i_cfg.quat_w); w_mb = 36'(r_t[1]); end
                    5'd4:    begin w_ma = 33'(i_cfg.quat_z); w_mb = 36'(r_t[0]); end
                    5'd5:    begin w_ma = 33'(i_cfg.quat_x); w_mb = 36'(r_t[2]); end
                    5'd6:    begin w_ma = 33'(i_cfg.quat_w); w_mb = 36'(r_t[2]); end
                    5'd7:    begin w_ma = 33'(i_cfg.quat_x); w_mb = 36'(r_t[1]); end
                    5'd8:    begin w_ma = 33'(i_cfg.quat_y); w_mb = 36'(r_t[0]); end
                    default: ;
                endcase
            end
            S_EMA: begin
                case (r_step)
                    5'd0:    begin w_ma = 33'(w_alpha); w_mb = 36'(r_r[0]); end
                    5'd1:    begin w_ma = 33'(w_beta);  w_mb = 36'(r_accum[0]); end
                    5'd2:    begin w_ma = 33'(w_alpha); w_mb = 36'(r_r[1]); end
                    5'd3:    begin w_ma = 33'(w_beta);  w_mb = 36'(r_accum[1]); end
                    5'd4:    begin w_ma = 33'(w_alpha); w_mb = 36'(r_r[2]); end
                    5'd5:    begin w_ma = 33'(w_beta);  w_mb = 36'(r_accum[2]); end
                    default: ;
                endcase
            end
            S_SQ: begin
                case (r_step)
                    5'd0:    begin w_ma = 33'(r_mag[0]); w_mb = 36'(r_mag[0]); end
                    5'd1:    begin w_ma = 33'(r_mag[1]); w_mb = 36'(r_mag[1]); end
                    5'd2:    begin w_ma = 33'(r_mag[2]); w_mb = 36'(r_mag[2]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_g[0] <= i_item.gx;
                r_g[1] <= i_item.gy;
                r_g[2] <= i_item.gz;
            end
            S_CHECK: begin
                if (r_step == 5'd1) begin
                    r_acc <= w_p;
                end else if (r_step == 5'd2 || r_step == 5'd3) begin
                    r_acc <= r_acc + w_p;
                end
            end
            S_ROT1: begin
                case (r_step)
                    5'd1, 5'd3, 5'd5: r_acc <= w_p;
                    5'd2:    r_t[0] <= 35'((r_acc - w_p) <<< 1);
                    5'd4:    r_t[1] <= 35'((r_acc - w_p) <<< 1);
                    5'd6:    r_t[2] <= 35'((r_acc - w_p) <<< 1);
                    default: ;
                endcase
            end
            S_ROT2: begin
                case (r_step)
                    5'd1:    r_acc <= (64'(r_g[0]) <<< 28) + w_p;
                    5'd4:    r_acc <= (64'(r_g[1]) <<< 28) + w_p;
                    5'd7:    r_acc <= (64'(r_g[2]) <<< 28) + w_p;
                    5'd2, 5'd5, 5'd8: r_acc <= r_acc + w_p;
                    5'd3:    r_r[0] <= rnd28(r_acc - w_p);
                    5'd6:    r_r[1] <= rnd28(r_acc - w_p);
                    5'd9:    r_r[2] <= rnd28(r_acc - w_p);
                    default: ;
                endcase
            end
            S_EMA: begin
                if (r_step == 5'd1 || r_step == 5'd3 || r_step == 5'd5) begin
                    r_acc <= w_p;
                end
            end
            S_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= r_accum[i][31] ? 32'(-r_accum[i]) : 32'(r_accum[i]);
                    r_neg[i] <= r_accum[i][31];
                end
                if (r_accum[0] == 0 && r_accum[1] == 0 && r_accum[2] == 0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_dir[i] <= '0;
                    end
                end
            end
            S_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_or[31:30] != 2'b00) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (!w_or[29]) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            S_SQ: begin
                if (r_step == 5'd1) begin
                    r_acc <= w_p;
                end else if (r_step == 5'd2) begin
                    r_acc <= r_acc + w_p;
                end else if (r_step == 5'd3) begin
                    r_v    <= 64'(r_acc + w_p);
                    r_root <= '0;
                    r_bit  <= 64'h4000_0000_0000_0000;
                end
            end
            S_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v    <= r_v - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DIVSET: begin
                r_rem <= w_num[47:16];
                r_nlo <= w_num[15:0];
                r_q   <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? 32'(w_rem2 - {1'b0, r_root[31:0]}) : w_rem2[31:0];
                r_nlo <= r_nlo << 1;
                r_q   <= w_qn;
                if (r_step == 5'd15) begin
                    r_dir[r_axis] <= r_neg[r_axis] ? -$signed(w_qn) : $signed(w_qn);
                end
            end
            default: ;
        endcase
    end

    // Sequencer and the estimator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_axis    <= '0;
            r_samples <= '0;
            r_seen    <= 1'b0;
            r_fin     <= 1'b0;
            r_done    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_accum[i] <= '0;
            end
        end else begin
            r_step <= r_step + 5'd1;
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_item_valid) begin
                        if (i_item.command) begin
                            r_samples <= '0;
                            r_seen    <= 1'b0;
                            r_fin     <= 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                r_accum[i] <= '0;
                            end
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_step == 5'd4) begin
                        r_step  <= '0;
                        r_state <= (r_acc < w_p) ? S_IDLE : S_ROT1;
                    end
                end
                S_ROT1: begin
                    if (r_step == 5'd6) begin
                        r_step  <= '0;
                        r_state <= S_ROT2;
                    end
                end
                S_ROT2: begin
                    if (r_step == 5'd9) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_step <= '0;
                    if (w_cnt != '0) begin
                        if (r_fin) begin
                            r_state <= S_IDLE;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_accum[i] <= (r_samples == '0) ? r_r[i]
                                    : sat32(64'(r_accum[i]) + 64'(r_r[i]));
                            end
                            r_samples <= r_samples + 13'd1;
                            if ((r_samples + 13'd1) < w_cnt) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_fin   <= 1'b1;
                                r_seen  <= 1'b1;
                                r_done  <= 1'b1;
                                r_state <= S_NORM;
                            end
                        end
                    end else begin
                        r_done <= 1'b0;
                        if (!r_seen) begin
                            for (int i = 0; i < 3; i++) begin
                                r_accum[i] <= r_r[i];
                            end
                            r_seen  <= 1'b1;
                            r_state <= S_NORM;
                        end else begin
                            r_state <= S_EMA;
                        end
                    end
                end
                S_EMA: begin
                    case (r_step)
                        5'd2:    r_accum[0] <= rnd16_sat(r_acc + w_p);
                        5'd4:    r_accum[1] <= rnd16_sat(r_acc + w_p);
                        5'd6:    r_accum[2] <= rnd16_sat(r_acc + w_p);
                        default: ;
                    endcase
                    if (r_step == 5'd6) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_step <= '0;
                    if (r_accum[0] == 0 && r_accum[1] == 0 && r_accum[2] == 0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_step <= '0;
                    if (w_or[31:30] == 2'b00 && w_or[29]) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_step == 5'd3) begin
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == 5'd31) begin
                        r_axis  <= '0;
                        r_state <= S_DIVSET;
                    end
                end
                S_DIVSET: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == 5'd15) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DIVSET;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: the next sample may be worked on while this word waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_res.dir_x      <= r_dir[0];
            r_res.dir_y      <= r_dir[1];
            r_res.dir_z      <= r_dir[2];
            r_res.batch_done <= r_done;
        end
    end

endmodule

// ----- src/imu_gravity_direction_estimator.sv -----
// Channel   | Signals                      | Word
// ----------+------------------------------+---------------------------------------
// input     | s_axis_tvalid/tready         | tdata: accel_x, accel_y, accel_z
//           |                              | tuser: command
// output    | m_axis_tvalid/tready         | tdata: dir_x, dir_y, dir_z
//           |                              | tuser: batch_done
// config    | i_cfg_we/index/data          | one register per write
//
// A sample with a nonzero result passes in the back end through a shared
// 33x36 multiplier for the norm check, rotation, filter and sum of squares, a one
// bit per cycle normalizing shift, a 32-step square root and a 16-step divider run
// once per axis. A two-word queue lets the input side run ahead; the output
// register holds a result until it is taken. Reset is synchronous and restores
// the control and configuration registers.
module imu_gravity_direction_estimator import igde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic        s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    output logic        m_axis_tuser,   // batch_done [0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_pop;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quat_w        <= 16'sd16384;
            r_cfg.quat_x        <= '0;
            r_cfg.quat_y        <= '0;
            r_cfg.quat_z        <= '0;
            r_cfg.ema_alpha     <= ALPHA_ONE;
            r_cfg.average_count <= '0;
            r_cfg.min_norm      <= 16'd1;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_QUAT_W:    r_cfg.quat_w        <= i_cfg_data[15:0];
                REG_QUAT_X:    r_cfg.quat_x        <= i_cfg_data[15:0];
                REG_QUAT_Y:    r_cfg.quat_y        <= i_cfg_data[15:0];
                REG_QUAT_Z:    r_cfg.quat_z        <= i_cfg_data[15:0];
                REG_EMA_ALPHA: r_cfg.ema_alpha     <= i_cfg_data;
                REG_AVG_COUNT: r_cfg.average_count <= i_cfg_data[12:0];
                REG_MIN_NORM:  r_cfg.min_norm      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    igde_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    igde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_result     (w_res)
    );

    assign m_axis_tdata = {w_res.dir_z, w_res.dir_y, w_res.dir_x};
    assign m_axis_tuser = w_res.batch_done;

    // The back end never takes a word from an empty queue.
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("queue popped while empty");

    // A unit direction never exceeds one in any component.
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(w_res.dir_x) <= $signed(DIR_ONE)
            && $signed(w_res.dir_x) >= -$signed(DIR_ONE)
            && $signed(w_res.dir_y) <= $signed(DIR_ONE)
            && $signed(w_res.dir_y) >= -$signed(DIR_ONE)
            && $signed(w_res.dir_z) <= $signed(DIR_ONE)
            && $signed(w_res.dir_z) >= -$signed(DIR_ONE)))
        else $error("direction component out of range");

    // A word popped while the result is stalled must not disturb the held result.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(w_res)))
        else $error("held result changed");

endmodule

// ----- test/tb_top.sv -----
module tb_top import igde_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE   = 600;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_OFF = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    imu_gravity_direction_estimator dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of registers and filter state.
    t_cfg   cfg;
    longint accum [3];
    int     batch_len;
    bit     filter_seeded;
    bit     batch_closed;

    t_result dir_queue [$];
    int      mismatches = 0;
    int      words_in = 0;
    int      words_out = 0;
    int      batches_out = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_request = 1'b0;
    int      quiet_cycles = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (mag(v) + (longint'(1) << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_result unit_direction(longint v [3]);
        t_result res;
        longint c [3];
        longint unsigned m, ss, n, q;
        m = 0;
        ss = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            c[i] = v[i];
            if (mag(c[i]) > m) m = mag(c[i]);
        end
        if (m == 0) return res;
        // Bring the largest component into [2^29, 2^30), truncating toward zero.
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) c[i] = c[i] / 2;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) c[i] = c[i] * 2;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++) ss += mag(c[i]) * mag(c[i]);
        n = floor_sqrt(ss);
        q = (mag(c[0]) * 16384 + n / 2) / n;
        res.dir_x = 16'(c[0] < 0 ? -q : q);
        q = (mag(c[1]) * 16384 + n / 2) / n;
        res.dir_y = 16'(c[1] < 0 ? -q : q);
        q = (mag(c[2]) * 16384 + n / 2) / n;
        res.dir_z = 16'(c[2] < 0 ? -q : q);
        return res;
    endfunction

    // Updates the filter state for one word; returns 1 when a direction comes out.
    function automatic bit estimate_gravity(bit cmd, logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] az, output t_result res);
        longint g [3], t [3], r [3];
        longint w, ux, uy, uz, ss, lim, alpha, count;
        res = '0;
        if (cmd) begin
            accum = '{0, 0, 0};
            batch_len = 0;
            filter_seeded = 0;
            batch_closed = 0;
            return 0;
        end
        g[0] = -longint'($signed(ax));
        g[1] = -longint'($signed(ay));
        g[2] = -longint'($signed(az));
        ss = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
        lim = longint'(cfg.min_norm) * longint'(cfg.min_norm);
        if (ss < lim) return 0;
        w = cfg.quat_w;
        ux = cfg.quat_x;
        uy = cfg.quat_y;
        uz = cfg.quat_z;
        t[0] = 2 * (uy * g[2] - uz * g[1]);
        t[1] = 2 * (uz * g[0] - ux * g[2]);
        t[2] = 2 * (ux * g[1] - uy * g[0]);
        r[0] = round_shift((g[0] <<< 28) + w * t[0] + (uy * t[2] - uz * t[1]), 28);
        r[1] = round_shift((g[1] <<< 28) + w * t[1] + (uz * t[0] - ux * t[2]), 28);
        r[2] = round_shift((g[2] <<< 28) + w * t[2] + (ux * t[1] - uy * t[0]), 28);
        count = cfg.average_count > MAX_AVERAGE ? MAX_AVERAGE : cfg.average_count;
        if (count > 0) begin
            if (batch_closed) return 0;
            for (int i = 0; i < 3; i++)
                accum[i] = sat_word(batch_len == 0 ? r[i] : accum[i] + r[i]);
            batch_len++;
            if (batch_len < count) return 0;
            batch_closed = 1;
            filter_seeded = 1;
            res = unit_direction(accum);
            res.batch_done = 1'b1;
            return 1;
        end
        alpha = cfg.ema_alpha > ALPHA_ONE ? ALPHA_ONE : cfg.ema_alpha;
        for (int i = 0; i < 3; i++)
            accum[i] = filter_seeded ?
                sat_word(round_shift(alpha * r[i] + (65536 - alpha) * accum[i], 16)) :
                sat_word(r[i]);
        filter_seeded = 1;
        res = unit_direction(accum);
        return 1;
    endfunction

    task automatic write_reg(t_reg_index idx, logic [16:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_QUAT_W:    cfg.quat_w = value[15:0];
            REG_QUAT_X:    cfg.quat_x = value[15:0];
            REG_QUAT_Y:    cfg.quat_y = value[15:0];
            REG_QUAT_Z:    cfg.quat_z = value[15:0];
            REG_EMA_ALPHA: cfg.ema_alpha = value;
            REG_AVG_COUNT: cfg.average_count = value[12:0];
            REG_MIN_NORM:  cfg.min_norm = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (dir_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offers one word; a typed expectation, when given, replaces the predicted one.
    task automatic send_word(bit cmd, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             bit typed, t_result typed_res);
        t_result res;
        i_cfg_we <= 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {az, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        words_in++;
        if (estimate_gravity(cmd, ax, ay, az, res) || typed)
            dir_queue.insert(dir_queue.size(), typed ? typed_res : res);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            2: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    task automatic random_words(int n, int reset_pct);
        for (int k = 0; k < n; k++)
            send_word($urandom_range(99) < reset_pct, pick_axis(), pick_axis(), pick_axis(),
                      1'b0, '0);
    endtask

    typedef struct {
        bit              cmd;
        logic [15:0]     ax, ay, az;
        bit              typed;
        logic [15:0]     ex, ey, ez;
    } t_row;

    t_row directed [] = '{
        '{0, 16'd0,      16'd0,      -16'sd1000, 1, 16'd0,     16'd0,     16'd16384},
        '{0, -16'sd16384, 16'd0,     16'd0,      1, 16'd16384, 16'd0,     16'd0},
        '{0, 16'h8000,   16'd0,      16'd0,      1, 16'd16384, 16'd0,     16'd0},
        '{0, 16'h7FFF,   16'd0,      16'd0,      1, -16'sd16384, 16'd0,   16'd0},
        '{0, 16'd0,      16'h8000,   16'd0,      1, 16'd0,     16'd16384, 16'd0},
        '{0, 16'd0,      16'd0,      16'h7FFF,   1, 16'd0,     16'd0,     -16'sd16384},
        '{0, 16'd0,      16'd0,      16'd0,      0, 0, 0, 0},
        '{1, 16'hFFFF,   16'hFFFF,   16'hFFFF,   0, 0, 0, 0},
        '{0, 16'hFFFF,   16'hFFFF,   16'hFFFF,   0, 0, 0, 0},
        '{0, 16'h8000,   16'h8000,   16'h8000,   0, 0, 0, 0},
        '{0, 16'h7FFF,   16'h8000,   16'd1234,   0, 0, 0, 0},
        '{0, 16'd100,    -16'sd200,  16'd300,    0, 0, 0, 0},
        '{1, 16'd0,      16'd0,      16'd0,      0, 0, 0, 0},
        '{0, 16'd1,      16'd0,      16'd0,      0, 0, 0, 0},
        '{0, 16'h5555,   16'hAAAA,   16'h0F0F,   0, 0, 0, 0},
        '{0, 16'hAAAA,   16'h5555,   16'hF0F0,   0, 0, 0, 0}
    };

    initial begin
        t_result typed_res;
        cfg = '{quat_w: 16'sd16384, quat_x: '0, quat_y: '0, quat_z: '0,
                ema_alpha: ALPHA_ONE, average_count: '0, min_norm: 16'd1};
        accum = '{0, 0, 0};
        batch_len = 0;
        filter_seeded = 0;
        batch_closed = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            typed_res = '{dir_x: directed[i].ex, dir_y: directed[i].ey,
                          dir_z: directed[i].ez, batch_done: 1'b0};
            send_word(directed[i].cmd, directed[i].ax, directed[i].ay, directed[i].az,
                      directed[i].typed, typed_res);
        end

        for (int phase = 0; phase < 12; phase++) begin
            drain();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (phase)
                0: begin
                    write_reg(REG_QUAT_W, 17'd11585);
                    write_reg(REG_QUAT_Z, 17'd11585);
                    write_reg(REG_EMA_ALPHA, 17'd4096);
                end
                1: write_reg(REG_EMA_ALPHA, 17'd0);
                2: begin
                    write_reg(REG_EMA_ALPHA, 17'h1FFFF);
                    write_reg(REG_QUAT_X, 17'h08000);
                    write_reg(REG_QUAT_Y, 17'h07FFF);
                end
                3: begin
                    write_reg(REG_AVG_COUNT, 17'd5);
                    write_reg(REG_QUAT_W, 17'h07FFF);
                end
                4: write_reg(REG_AVG_COUNT, 17'd1);
                5: begin
                    // Long batches with full-scale rotation accumulate large sums.
                    write_reg(REG_AVG_COUNT, 17'd40);
                    write_reg(REG_QUAT_W, 17'h08000);
                    write_reg(REG_QUAT_Z, 17'h08000);
                end
                6: begin
                    // Batch may be closed or partial; continuous mode carries on from it.
                    write_reg(REG_AVG_COUNT, 17'd0);
                    write_reg(REG_EMA_ALPHA, 17'd30000);
                end
                7: begin
                    write_reg(REG_MIN_NORM, 17'hFFFF);
                    write_reg(REG_QUAT_W, 17'd16384);
                    write_reg(REG_QUAT_X, 17'd0);
                    write_reg(REG_QUAT_Y, 17'd0);
                    write_reg(REG_QUAT_Z, 17'd0);
                end
                8: begin
                    write_reg(REG_MIN_NORM, 17'd0);
                    write_reg(REG_AVG_COUNT, 17'h1FFF);
                end
                9: begin
                    write_reg(REG_AVG_COUNT, 17'd3);
                    write_reg(REG_MIN_NORM, 17'd5000);
                end
                10: begin
                    write_reg(REG_AVG_COUNT, 17'd0);
                    write_reg(REG_QUAT_X, 17'd6000);
                    write_reg(REG_EMA_ALPHA, 17'd65535);
                end
                default: begin
                    write_reg(REG_QUAT_W, 17'h0);
                    write_reg(REG_MIN_NORM, 17'd1);
                end
            endcase
            if (phase == 2) begin
                hold_request = 1'b1;
                random_words(20, 2);
            end
            random_words(phase == 7 ? 40 : 100, phase inside {3, 4, 5, 9} ? 8 : 2);
        end
        drain();
        $display("Sent %0d words, checked %0d directions (%0d batch results),",
                 words_in, words_out, batches_out);
        $display("over rotation, filter weight, batch size and norm threshold extremes.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_OFF) @(posedge i_clk);
            hold_request = 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{dir_x: m_axis_tdata[15:0], dir_y: m_axis_tdata[31:16],
                    dir_z: m_axis_tdata[47:32], batch_done: m_axis_tuser};
            words_out++;
            if (got.batch_done) batches_out++;
            if (dir_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
                want = dir_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- imu_gravity_direction_estimator.f -----
src/igde_pkg.sv
src/igde_front.sv
src/igde_back.sv
src/imu_gravity_direction_estimator.sv
test/tb_top.sv
